// ===== src/assert_macros.svh =====
// assert_macros.svh
// assertion macros for the earth frame accel filter rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EFAB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EFAB_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFAB_ASSERT(lbl, clk, rst_n, prop, msg)
`define EFAB_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== src/efab_pkg.sv =====
`timescale 1ns / 1ps
// efab_pkg: widths, codes, types and product step tables
// used by efab_lane and earth_frame_accel_bias_filter_top
package efab_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int SUM_W       = 48;
    localparam int ACC_W       = 26;
    localparam int OPD_W       = 17;
    localparam int PAIR_W      = 32;
    localparam int TERM_W      = 64;
    localparam int RAW_SHIFT   = 26;
    localparam int CNT_W       = TERM_W - RAW_SHIFT;
    localparam int SCALE_W     = 18;
    localparam int SPROD_W     = CNT_W + SCALE_W + 1;
    localparam int SCALE_SHIFT = 32 - FRAC_BITS;
    localparam int ASC_W       = SPROD_W - SCALE_SHIFT;
    localparam int DIFF_W      = ACC_W + 1;
    localparam int GAIN_W      = 16;
    localparam int BPROD_W     = DIFF_W + GAIN_W + 1;
    localparam int BLEND_SHIFT = 16;
    localparam int BSTEP_W     = BPROD_W - BLEND_SHIFT;
    localparam int GRAV_W      = 12;
    localparam int DB_W        = 12;
    localparam int CMP_W       = DIFF_W + DB_W + FRAC_BITS;
    localparam int COUNT_W     = 16;
    localparam int NUM_LANES   = 3;
    localparam int LANE_W      = 2;
    localparam int NUM_STEPS   = 5;
    localparam int STEP_W      = 3;
    localparam int MAC_LAST    = NUM_STEPS + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;

    localparam int ACC_MAX = 2 ** (ACC_W - 1) - 1;
    localparam int ACC_MIN = -(2 ** (ACC_W - 1));

    localparam logic [GRAV_W-1:0]  RST_GRAVITY  = GRAV_W'(512);
    localparam logic [SCALE_W-1:0] RST_SCALE    = SCALE_W'(125524);
    localparam logic [GAIN_W-1:0]  RST_GAIN_DIS = GAIN_W'(983);
    localparam logic [GAIN_W-1:0]  RST_GAIN_ARM = GAIN_W'(85);
    localparam logic [DB_W-1:0]    RST_DEADBAND = DB_W'(80);
    localparam logic [GAIN_W-1:0]  RST_SMOOTH   = GAIN_W'(9362);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY  = 3'd0,
        CFG_SCALE    = 3'd1,
        CFG_GAIN_DIS = 3'd2,
        CFG_GAIN_ARM = 3'd3,
        CFG_DEADBAND = 3'd4,
        CFG_SMOOTH   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OPD_ZERO, OPD_ONE, OPD_AR, OPD_AP, OPD_AY, OPD_CR,
        OPD_SR, OPD_CP, OPD_SP, OPD_CY, OPD_SY, OPD_G
    } t_opd;

    typedef enum logic [1:0] {SH_0, SH_14, SH_28, SH_42} t_shift;

    typedef struct packed {
        t_opd   x;
        t_opd   y;
        t_opd   v;
        t_opd   w;
        t_shift sh;
        logic   neg;
    } t_step;

    typedef struct packed {
        logic signed [OPD_W-1:0] ar;
        logic signed [OPD_W-1:0] ap;
        logic signed [OPD_W-1:0] ay;
        logic signed [OPD_W-1:0] cr;
        logic signed [OPD_W-1:0] sr;
        logic signed [OPD_W-1:0] cp;
        logic signed [OPD_W-1:0] sp;
        logic signed [OPD_W-1:0] cy;
        logic signed [OPD_W-1:0] sy;
        logic signed [OPD_W-1:0] g;
    } t_ops;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [GAIN_W-1:0]  gain_dis;
        logic [GAIN_W-1:0]  gain_arm;
        logic [DB_W-1:0]    deadband;
        logic [GAIN_W-1:0]  smooth;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic              a_en;
        logic [STEP_W-1:0] step;
        logic              round;
        logic              scale;
        logic              clamp;
        logic              diff;
        logic              blend;
        logic              bias;
        logic              smooth;
        logic              accum;
        logic              armed;
        logic              clr;
    } t_ctl;

    typedef struct packed {
        logic signed [ACC_W-1:0] diff;
        logic signed [ACC_W-1:0] smooth;
        logic signed [SUM_W-1:0] sum;
    } t_lane_res;

    function automatic logic signed [OPD_W-1:0] opd_sel(t_ops ops, t_opd code);
        logic signed [OPD_W-1:0] v;
        unique case (code)
            OPD_ZERO: v = '0;
            OPD_ONE:  v = OPD_W'(1);
            OPD_AR:   v = ops.ar;
            OPD_AP:   v = ops.ap;
            OPD_AY:   v = ops.ay;
            OPD_CR:   v = ops.cr;
            OPD_SR:   v = ops.sr;
            OPD_CP:   v = ops.cp;
            OPD_SP:   v = ops.sp;
            OPD_CY:   v = ops.cy;
            OPD_SY:   v = ops.sy;
            OPD_G:    v = ops.g;
            default:  v = '0;
        endcase
        return v;
    endfunction

    function automatic t_step mk_step(t_opd x, t_opd y, t_opd v, t_opd w,
                                      t_shift sh, logic neg);
        t_step s;
        s.x   = x;
        s.y   = y;
        s.v   = v;
        s.w   = w;
        s.sh  = sh;
        s.neg = neg;
        return s;
    endfunction

    // term = (x*y) * (v*w) << sh, subtracted when neg
    function automatic t_step step_of(logic [LANE_W-1:0] lane, logic [STEP_W-1:0] idx);
        t_step s;
        s = mk_step(OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, SH_0, 1'b0);
        unique case ({lane, idx})
            {2'd0, 3'd0}: s = mk_step(OPD_CP, OPD_CY, OPD_AP, OPD_ONE, SH_14, 1'b1);
            {2'd0, 3'd1}: s = mk_step(OPD_SR, OPD_AR, OPD_SP, OPD_CY, SH_0, 1'b1);
            {2'd0, 3'd2}: s = mk_step(OPD_CR, OPD_SY, OPD_AR, OPD_ONE, SH_14, 1'b0);
            {2'd0, 3'd3}: s = mk_step(OPD_SR, OPD_SY, OPD_AY, OPD_ONE, SH_14, 1'b1);
            {2'd0, 3'd4}: s = mk_step(OPD_CR, OPD_AY, OPD_SP, OPD_CY, SH_0, 1'b1);
            {2'd1, 3'd0}: s = mk_step(OPD_CP, OPD_SY, OPD_AP, OPD_ONE, SH_14, 1'b1);
            {2'd1, 3'd1}: s = mk_step(OPD_CR, OPD_CY, OPD_AR, OPD_ONE, SH_14, 1'b1);
            {2'd1, 3'd2}: s = mk_step(OPD_SR, OPD_AR, OPD_SP, OPD_SY, SH_0, 1'b1);
            {2'd1, 3'd3}: s = mk_step(OPD_SR, OPD_CY, OPD_AY, OPD_ONE, SH_14, 1'b0);
            {2'd1, 3'd4}: s = mk_step(OPD_CR, OPD_AY, OPD_SP, OPD_SY, SH_0, 1'b1);
            {2'd2, 3'd0}: s = mk_step(OPD_SP, OPD_AP, OPD_ONE, OPD_ONE, SH_28, 1'b1);
            {2'd2, 3'd1}: s = mk_step(OPD_SR, OPD_CP, OPD_AR, OPD_ONE, SH_14, 1'b0);
            {2'd2, 3'd2}: s = mk_step(OPD_CR, OPD_CP, OPD_AY, OPD_ONE, SH_14, 1'b0);
            {2'd2, 3'd3}: s = mk_step(OPD_G, OPD_ONE, OPD_ONE, OPD_ONE, SH_42, 1'b1);
            default: ;
        endcase
        return s;
    endfunction

endpackage

// ===== src/earth_frame_accel_bias_filter_top.sv =====
`timescale 1ns / 1ps
// earth_frame_accel_bias_filter_top: config registers, sequencer, three axis lanes
// and the merging output stage; depends on efab_pkg, efab_lane, assert_macros.svh
//
// usage
//   input word: three raw accel axes, roll/pitch/yaw sines and cosines (q14),
//   armed and clear_sums, taken on i_valid && o_ready
//   output word: bias-removed and low-passed earth frame acceleration per axis,
//   saturating sums and sample count, taken on o_valid && i_ready
//   config: i_cfg_we writes register i_cfg_idx from i_cfg_data; the user must
//   write only while idle, as the block itself does not enforce it
//   a new word is taken only in idle, after the last one has reached the output
//   register; the three lanes run in lockstep, each through a product accumulate
//   over five product steps and nine scaling, bias, low-pass and sum steps
//   the output register holds a finished word while the next one is computed;
//   a stalled receiver holds the block in its last step until the word is taken
//   reset: config returns to defaults, bias, low-pass state, sums and count
//   clear to zero, no word is pending
//
`include "assert_macros.svh"
module earth_frame_accel_bias_filter_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [15:0]                   i_accel_roll_axis,
    input  logic signed [15:0]                   i_accel_pitch_axis,
    input  logic signed [15:0]                   i_accel_yaw_axis,
    input  logic signed [15:0]                   i_cos_roll,
    input  logic signed [15:0]                   i_sin_roll,
    input  logic signed [15:0]                   i_cos_pitch,
    input  logic signed [15:0]                   i_sin_pitch,
    input  logic signed [15:0]                   i_cos_yaw,
    input  logic signed [15:0]                   i_sin_yaw,
    input  logic                                 i_armed,
    input  logic                                 i_clear_sums,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [efab_pkg::ACC_W-1:0]    o_earth_accel_x,
    output logic signed [efab_pkg::ACC_W-1:0]    o_earth_accel_y,
    output logic signed [efab_pkg::ACC_W-1:0]    o_earth_accel_z,
    output logic signed [efab_pkg::ACC_W-1:0]    o_smoothed_x,
    output logic signed [efab_pkg::ACC_W-1:0]    o_smoothed_y,
    output logic signed [efab_pkg::ACC_W-1:0]    o_smoothed_z,
    output logic signed [efab_pkg::SUM_W-1:0]    o_sum_x,
    output logic signed [efab_pkg::SUM_W-1:0]    o_sum_y,
    output logic signed [efab_pkg::SUM_W-1:0]    o_sum_z,
    output logic [efab_pkg::COUNT_W-1:0]         o_sample_count,
    input  logic                                 i_cfg_we,
    input  logic [efab_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [efab_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int OPD_W   = efab_pkg::OPD_W;
    localparam int STEP_W  = efab_pkg::STEP_W;
    localparam int COUNT_W = efab_pkg::COUNT_W;
    localparam int LANE_W  = efab_pkg::LANE_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_MAC    = 11'b000_0000_0010,
        S_ROUND  = 11'b000_0000_0100,
        S_SCALE  = 11'b000_0000_1000,
        S_CLAMP  = 11'b000_0001_0000,
        S_DIFF   = 11'b000_0010_0000,
        S_BLEND  = 11'b000_0100_0000,
        S_BIAS   = 11'b000_1000_0000,
        S_SMOOTH = 11'b001_0000_0000,
        S_ACCUM  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [STEP_W-1:0]              r_step;
    efab_pkg::t_ops                 r_ops;
    logic                           r_armed, r_clr;
    logic [efab_pkg::GRAV_W-1:0]    r_gravity;
    efab_pkg::t_cfg                 r_cfg;
    logic [COUNT_W-1:0]             r_count;
    logic                           r_out_vld;
    efab_pkg::t_ctl                 w_ctl;
    efab_pkg::t_lane_res            w_res [efab_pkg::NUM_LANES];
    logic                           w_in_acc, w_load;

    assign o_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_valid  = r_out_vld && i_rst_n;
    assign w_in_acc = i_valid && o_ready;
    assign w_load   = (r_state == S_DONE) && (!r_out_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity      <= efab_pkg::RST_GRAVITY;
            r_cfg.scale    <= efab_pkg::RST_SCALE;
            r_cfg.gain_dis <= efab_pkg::RST_GAIN_DIS;
            r_cfg.gain_arm <= efab_pkg::RST_GAIN_ARM;
            r_cfg.deadband <= efab_pkg::RST_DEADBAND;
            r_cfg.smooth   <= efab_pkg::RST_SMOOTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                efab_pkg::CFG_GRAVITY:  r_gravity      <= i_cfg_data[efab_pkg::GRAV_W-1:0];
                efab_pkg::CFG_SCALE:    r_cfg.scale    <= i_cfg_data[efab_pkg::SCALE_W-1:0];
                efab_pkg::CFG_GAIN_DIS: r_cfg.gain_dis <= i_cfg_data[efab_pkg::GAIN_W-1:0];
                efab_pkg::CFG_GAIN_ARM: r_cfg.gain_arm <= i_cfg_data[efab_pkg::GAIN_W-1:0];
                efab_pkg::CFG_DEADBAND: r_cfg.deadband <= i_cfg_data[efab_pkg::DB_W-1:0];
                efab_pkg::CFG_SMOOTH:   r_cfg.smooth   <= i_cfg_data[efab_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // input word capture, pitch terms negated
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ops.ar <= OPD_W'(i_accel_roll_axis);
            r_ops.ap <= OPD_W'(i_accel_pitch_axis);
            r_ops.ay <= OPD_W'(i_accel_yaw_axis);
            r_ops.cr <= OPD_W'(i_cos_roll);
            r_ops.sr <= OPD_W'(i_sin_roll);
            r_ops.cp <= -(OPD_W'(i_cos_pitch));
            r_ops.sp <= -(OPD_W'(i_sin_pitch));
            r_ops.cy <= OPD_W'(i_cos_yaw);
            r_ops.sy <= OPD_W'(i_sin_yaw);
            r_ops.g  <= $signed(OPD_W'(r_gravity));
            r_armed  <= i_armed;
            r_clr    <= i_clear_sums;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_MAC;
            S_MAC:    if (r_step == STEP_W'(efab_pkg::MAC_LAST)) n_state = S_ROUND;
            S_ROUND:  n_state = S_SCALE;
            S_SCALE:  n_state = S_CLAMP;
            S_CLAMP:  n_state = S_DIFF;
            S_DIFF:   n_state = S_BLEND;
            S_BLEND:  n_state = S_BIAS;
            S_BIAS:   n_state = S_SMOOTH;
            S_SMOOTH: n_state = S_ACCUM;
            S_ACCUM:  n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_step <= '0;
            end else if (r_state == S_MAC) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_comb begin
        w_ctl.start  = w_in_acc;
        w_ctl.a_en   = (r_state == S_MAC) && (r_step < STEP_W'(efab_pkg::NUM_STEPS));
        w_ctl.step   = r_step;
        w_ctl.round  = (r_state == S_ROUND);
        w_ctl.scale  = (r_state == S_SCALE);
        w_ctl.clamp  = (r_state == S_CLAMP);
        w_ctl.diff   = (r_state == S_DIFF);
        w_ctl.blend  = (r_state == S_BLEND);
        w_ctl.bias   = (r_state == S_BIAS);
        w_ctl.smooth = (r_state == S_SMOOTH);
        w_ctl.accum  = (r_state == S_ACCUM);
        w_ctl.armed  = r_armed;
        w_ctl.clr    = r_clr;
    end

    for (genvar g = 0; g < efab_pkg::NUM_LANES; g++) begin : g_lane
        efab_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (LANE_W'(g)),
            .i_ops   (r_ops),
            .i_cfg   (r_cfg),
            .i_ctl   (w_ctl),
            .o_res   (w_res[g])
        );
    end

    // merge: shared sample count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_ACCUM) begin
                if (r_clr) begin
                    r_count <= COUNT_W'(1);
                end else if (r_count != '1) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_earth_accel_x <= w_res[0].diff;
            o_earth_accel_y <= w_res[1].diff;
            o_earth_accel_z <= w_res[2].diff;
            o_smoothed_x    <= w_res[0].smooth;
            o_smoothed_y    <= w_res[1].smooth;
            o_smoothed_z    <= w_res[2].smooth;
            o_sum_x         <= w_res[0].sum;
            o_sum_y         <= w_res[1].sum;
            o_sum_z         <= w_res[2].sum;
            o_sample_count  <= r_count;
        end
    end

    `EFAB_ASSERT(a_accept_starts, i_clk, i_rst_n, w_in_acc |=> (r_state == S_MAC) && (r_step == '0), "accepted word did not start product accumulate")
    `EFAB_ASSERT(a_step_range, i_clk, i_rst_n, (r_state == S_MAC) |-> (r_step <= STEP_W'(efab_pkg::MAC_LAST)), "product step overran")
    `EFAB_ASSERT(a_done_holds, i_clk, i_rst_n, (r_state == S_DONE) && r_out_vld && !i_ready |=> (r_state == S_DONE) && r_out_vld, "finished word lost while output stalled")
    `EFAB_ASSERT(a_count_set, i_clk, i_rst_n, w_load |=> o_valid && (o_sample_count != '0), "output word without sample count")
    `EFAB_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE) && !r_out_vld, "reset did not return to idle")
endmodule

// ===== src/efab_lane.sv =====
`timescale 1ns / 1ps
// efab_lane: one earth axis; product accumulate, scaling, bias, low-pass, sum
// depends on efab_pkg
module efab_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [efab_pkg::LANE_W-1:0] i_lane,
    input  efab_pkg::t_ops            i_ops,
    input  efab_pkg::t_cfg            i_cfg,
    input  efab_pkg::t_ctl            i_ctl,
    output efab_pkg::t_lane_res       o_res
);

    localparam int OPD_W   = efab_pkg::OPD_W;
    localparam int PAIR_W  = efab_pkg::PAIR_W;
    localparam int TERM_W  = efab_pkg::TERM_W;
    localparam int CNT_W   = efab_pkg::CNT_W;
    localparam int SPROD_W = efab_pkg::SPROD_W;
    localparam int ASC_W   = efab_pkg::ASC_W;
    localparam int ACC_W   = efab_pkg::ACC_W;
    localparam int DIFF_W  = efab_pkg::DIFF_W;
    localparam int BPROD_W = efab_pkg::BPROD_W;
    localparam int BSTEP_W = efab_pkg::BSTEP_W;
    localparam int CMP_W   = efab_pkg::CMP_W;
    localparam int SUM_W   = efab_pkg::SUM_W;
    localparam int GAIN_W  = efab_pkg::GAIN_W;
    localparam int SC_SH   = efab_pkg::SCALE_SHIFT;
    localparam int BL_SH   = efab_pkg::BLEND_SHIFT;
    localparam int RAW_SH  = efab_pkg::RAW_SHIFT;

    localparam logic signed [TERM_W-1:0]  RAW_HALF = TERM_W'(1) << (RAW_SH - 1);
    localparam logic signed [SPROD_W-1:0] SC_HALF  = SPROD_W'(1) << (SC_SH - 1);
    localparam logic signed [BPROD_W-1:0] BL_HALF  = BPROD_W'(1) << (BL_SH - 1);
    localparam logic signed [ASC_W-1:0]   A_HI     = ASC_W'(efab_pkg::ACC_MAX);
    localparam logic signed [ASC_W-1:0]   A_LO     = ASC_W'(efab_pkg::ACC_MIN);
    localparam logic signed [DIFF_W-1:0]  D_HI     = DIFF_W'(efab_pkg::ACC_MAX);
    localparam logic signed [DIFF_W-1:0]  D_LO     = DIFF_W'(efab_pkg::ACC_MIN);
    localparam logic signed [SUM_W-1:0]   SUM_MAX  = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN  = {1'b1, {(SUM_W - 1){1'b0}}};

    efab_pkg::t_step w_step;
    logic signed [2*OPD_W-1:0]  w_p_full;
    logic signed [2*OPD_W-1:0]  w_q_full;
    logic signed [2*PAIR_W-1:0] w_term_full;
    logic signed [TERM_W-1:0]   w_term_sh;

    logic signed [PAIR_W-1:0] r_p, r_q;
    logic                     r_a_vld, r_b_vld;
    efab_pkg::t_shift         r_a_sh, r_b_sh;
    logic                     r_a_neg, r_b_neg;
    logic signed [TERM_W-1:0] r_term, r_acc;

    logic signed [TERM_W-1:0]  w_raw_rnd;
    logic signed [SPROD_W-1:0] n_sprod;
    logic signed [SPROD_W-1:0] w_sc_rnd;
    logic signed [ASC_W-1:0]   w_asc;
    logic signed [ACC_W-1:0]   n_a;
    logic [GAIN_W-1:0]         w_gain;
    logic signed [BPROD_W-1:0] n_bprod, n_eprod;
    logic signed [CMP_W-1:0]   w_d_cmp, w_db;
    logic                      n_upd;
    logic signed [ACC_W-1:0]   n_diff;
    logic signed [BPROD_W-1:0] w_b_rnd, w_e_rnd;
    logic signed [BSTEP_W-1:0] w_bias_ext, w_smooth_ext;
    logic signed [SUM_W:0]     w_sum_ext;
    logic signed [SUM_W-1:0]   n_sum;

    logic signed [CNT_W-1:0]   r_counts;
    logic signed [SPROD_W-1:0] r_sprod;
    logic signed [ACC_W-1:0]   r_a, r_diff;
    logic signed [DIFF_W-1:0]  r_d, r_e;
    logic signed [BPROD_W-1:0] r_bprod, r_eprod;
    logic                      r_upd;
    logic signed [ACC_W-1:0]   r_bias, r_smooth;
    logic signed [SUM_W-1:0]   r_sum;

    // product accumulate: pair products, then their product, then shift and add or subtract
    always_comb begin
        w_step   = efab_pkg::step_of(i_lane, i_ctl.step);
        w_p_full = efab_pkg::opd_sel(i_ops, w_step.x) * efab_pkg::opd_sel(i_ops, w_step.y);
        w_q_full = efab_pkg::opd_sel(i_ops, w_step.v) * efab_pkg::opd_sel(i_ops, w_step.w);
        w_term_full = r_p * r_q;
        unique case (r_b_sh)
            efab_pkg::SH_0:  w_term_sh = r_term;
            efab_pkg::SH_14: w_term_sh = r_term <<< 14;
            efab_pkg::SH_28: w_term_sh = r_term <<< 28;
            efab_pkg::SH_42: w_term_sh = r_term <<< 42;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.a_en;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.a_en) begin
            r_p     <= w_p_full[PAIR_W-1:0];
            r_q     <= w_q_full[PAIR_W-1:0];
            r_a_sh  <= w_step.sh;
            r_a_neg <= w_step.neg;
        end
        if (r_a_vld) begin
            r_term  <= w_term_full[TERM_W-1:0];
            r_b_sh  <= r_a_sh;
            r_b_neg <= r_a_neg;
        end
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (r_b_vld) begin
            r_acc <= r_b_neg ? r_acc - w_term_sh : r_acc + w_term_sh;
        end
    end

    // scaling, clamping, bias tracking, low-pass and saturating sum
    always_comb begin
        w_raw_rnd = r_acc + RAW_HALF;
        n_sprod   = r_counts * $signed({1'b0, i_cfg.scale});
        w_sc_rnd  = r_sprod + SC_HALF;
        w_asc     = w_sc_rnd[SPROD_W-1:SC_SH];
        if (w_asc > A_HI) begin
            n_a = A_HI[ACC_W-1:0];
        end else if (w_asc < A_LO) begin
            n_a = A_LO[ACC_W-1:0];
        end else begin
            n_a = w_asc[ACC_W-1:0];
        end

        w_gain  = i_ctl.armed ? i_cfg.gain_arm : i_cfg.gain_dis;
        n_bprod = r_d * $signed({1'b0, w_gain});
        w_d_cmp = CMP_W'(r_d);
        w_db    = $signed(CMP_W'({i_cfg.deadband, efab_pkg::FRAC_BITS'(0)}));
        n_upd   = !i_ctl.armed || ((w_d_cmp <= w_db) && (w_d_cmp >= -w_db));
        if (r_d > D_HI) begin
            n_diff = D_HI[ACC_W-1:0];
        end else if (r_d < D_LO) begin
            n_diff = D_LO[ACC_W-1:0];
        end else begin
            n_diff = r_d[ACC_W-1:0];
        end

        w_b_rnd    = r_bprod + BL_HALF;
        w_bias_ext = BSTEP_W'(r_bias) + w_b_rnd[BPROD_W-1:BL_SH];
        n_eprod    = r_e * $signed({1'b0, i_cfg.smooth});
        w_e_rnd    = r_eprod + BL_HALF;
        w_smooth_ext = BSTEP_W'(r_smooth) + w_e_rnd[BPROD_W-1:BL_SH];

        w_sum_ext = (i_ctl.clr ? '0 : (SUM_W + 1)'(r_sum)) + (SUM_W + 1)'(r_smooth);
        if (w_sum_ext[SUM_W] != w_sum_ext[SUM_W-1]) begin
            n_sum = w_sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = w_sum_ext[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.round) begin
            r_counts <= w_raw_rnd[TERM_W-1:RAW_SH];
        end
        if (i_ctl.scale) begin
            r_sprod <= n_sprod;
        end
        if (i_ctl.clamp) begin
            r_a <= n_a;
        end
        if (i_ctl.diff) begin
            r_d <= DIFF_W'(r_a) - DIFF_W'(r_bias);
        end
        if (i_ctl.blend) begin
            r_bprod <= n_bprod;
            r_upd   <= n_upd;
            r_diff  <= n_diff;
            r_e     <= DIFF_W'(n_diff) - DIFF_W'(r_smooth);
        end
        if (i_ctl.bias) begin
            r_eprod <= n_eprod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias   <= '0;
            r_smooth <= '0;
            r_sum    <= '0;
        end else begin
            if (i_ctl.bias && r_upd) begin
                r_bias <= w_bias_ext[ACC_W-1:0];
            end
            if (i_ctl.smooth) begin
                r_smooth <= w_smooth_ext[ACC_W-1:0];
            end
            if (i_ctl.accum) begin
                r_sum <= n_sum;
            end
        end
    end

    assign o_res.diff   = r_diff;
    assign o_res.smooth = r_smooth;
    assign o_res.sum    = r_sum;

endmodule
